[rtl/assert_macros.svh]
// assertion macros used by the worm move step unit
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

[rtl/iwms_pkg.sv]
// shared types, sizes and helper functions for the worm move step unit
// no dependencies
package iwms_pkg;

  // lattice and counter sizes
  localparam int SIDE       = 64;
  localparam int COUNT_BITS = 16;
  localparam int COORD_W    = $clog2(SIDE);
  localparam int NBONDS     = 2 * SIDE * SIDE;
  localparam int BOND_W     = $clog2(NBONDS);
  localparam int SITE_W     = BOND_W - 1;

  // fixed field widths at the ports
  localparam int IN_COORD_W  = 6;
  localparam int DIR_W       = 2;
  localparam int DRAW_W      = 16;
  localparam int CFG_W       = 24;
  localparam int OUT_COORD_W = 6;
  localparam int OUT_BOND_W  = 13;
  localparam int OUT_COUNT_W = 16;
  localparam int KICK_W      = 48;
  localparam int SUM_W       = 29;
  localparam int RUN_W       = 48;

  // shared multiplier operand widths
  localparam int MA_W   = (DRAW_W > COUNT_BITS) ? DRAW_W : COUNT_BITS;
  localparam int MB_W   = (CFG_W > COUNT_BITS + 1) ? CFG_W : COUNT_BITS + 1;
  localparam int PROD_W = MA_W + MB_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [CFG_W-1:0]      CFG_RESET = CFG_W'(65536);
  localparam logic [KICK_W-1:0]     KICK_MAX  = '1;
  localparam logic [RUN_W-1:0]      RUN_MIN   = {1'b1, {(RUN_W-1){1'b0}}};

  typedef enum logic [DIR_W-1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef enum logic {
    REG_COUPLING    = 1'b0,
    REG_TEMPERATURE = 1'b1
  } cfg_reg_t;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t col;
    coord_t row;
  } site_t;

  // everything a move needs once the head and tail are known
  typedef struct packed {
    site_t             head;    // head after a possible kick
    site_t             tail;    // tail after a possible kick
    site_t             nbr;     // proposed new head
    logic [BOND_W-1:0] bidx;    // crossed bond
    logic              kicked;  // worm was closed, new kick placed
    logic              closes;  // head lands on tail if accepted
  } plan_t;

  function automatic coord_t wrap_inc(coord_t c);
    return (c == coord_t'(SIDE - 1)) ? '0 : c + coord_t'(1);
  endfunction

  function automatic coord_t wrap_dec(coord_t c);
    return (c == '0) ? coord_t'(SIDE - 1) : c - coord_t'(1);
  endfunction

  function automatic logic [SITE_W-1:0] site_index(site_t s);
    return SITE_W'(s.row) * SITE_W'(SIDE) + SITE_W'(s.col);
  endfunction

  // kick when closed, then the neighbor and the crossed bond
  function automatic plan_t plan_move(site_t head, site_t tail,
                                      logic [IN_COORD_W-1:0] kx,
                                      logic [IN_COORD_W-1:0] ky, dir_t dir);
    plan_t p;
    site_t start;
    site_t nbr;
    site_t from;
    logic  vert;
    p.kicked  = (head == tail);
    start.col = p.kicked ? coord_t'(kx % SIDE) : head.col;
    start.row = p.kicked ? coord_t'(ky % SIDE) : head.row;
    nbr       = start;
    case (dir)
      DIR_RIGHT: nbr.col = wrap_inc(start.col);
      DIR_DOWN:  nbr.row = wrap_inc(start.row);
      DIR_LEFT:  nbr.col = wrap_dec(start.col);
      default:   nbr.row = wrap_dec(start.row);
    endcase
    vert     = (dir == DIR_DOWN) || (dir == DIR_UP);
    from     = ((dir == DIR_RIGHT) || (dir == DIR_DOWN)) ? start : nbr;
    p.head   = start;
    p.tail   = p.kicked ? start : tail;
    p.nbr    = nbr;
    p.bidx   = {site_index(from), vert};
    p.closes = (nbr == p.tail);
    return p;
  endfunction

endpackage

[rtl/iwms_ram.sv]
// generic single-write, single-read memory with registered read data
// no dependencies
module iwms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/ising_worm_move_step_unit.sv]
// Worm move step unit: one Monte Carlo worm move on a periodic square lattice per
// input transfer, bond counts held in one synchronous RAM. After reset the unit
// zeroes the bond RAM, one entry per cycle, over all NBONDS (8192) entries; input
// ready stays low during that pass, configuration writes are taken at any time.
// After that it sustains one move per cycle while out_ready is high: an item is held
// in the input register, its bond is read at the RAM as it moves to the update stage,
// where the read data goes through the acceptance multiply and compare, is written
// back and the result is registered. The next move's bond address is picked from
// both outcomes of the move in flight, and a read of the bond just written is served
// from a forwarding register.
// Depends on iwms_pkg, iwms_ram and assert_macros.svh.
module ising_worm_move_step_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [iwms_pkg::IN_COORD_W-1:0]    in_kick_x,
  input  logic [iwms_pkg::IN_COORD_W-1:0]    in_kick_y,
  input  logic [iwms_pkg::DIR_W-1:0]         in_direction,
  input  logic                               in_add_bond,
  input  logic [iwms_pkg::DRAW_W-1:0]        in_accept_draw,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [iwms_pkg::OUT_COORD_W-1:0]   out_head_col,
  output logic [iwms_pkg::OUT_COORD_W-1:0]   out_head_row,
  output logic [iwms_pkg::OUT_COORD_W-1:0]   out_tail_col,
  output logic [iwms_pkg::OUT_COORD_W-1:0]   out_tail_row,
  output logic [iwms_pkg::OUT_BOND_W-1:0]    out_bond_index,
  output logic [iwms_pkg::OUT_COUNT_W-1:0]   out_bond_count,
  output logic                               out_accepted,
  output logic                               out_worm_closed,
  output logic [iwms_pkg::KICK_W-1:0]        out_kick_total,
  output logic [iwms_pkg::SUM_W-1:0]         out_bond_sum,
  output logic signed [iwms_pkg::RUN_W-1:0]  out_bond_sum_running,
  // configuration port
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [iwms_pkg::CFG_W-1:0]         cfg_wdata
);

  import iwms_pkg::*;

  `include "assert_macros.svh"

  // configuration
  logic [CFG_W-1:0] coupling_r;
  logic [CFG_W-1:0] temperature_r;

  // clearing pass
  logic [BOND_W-1:0] clear_idx_r;
  logic              clear_done_r;

  // input stage
  logic                  s1_valid_r;
  logic [IN_COORD_W-1:0] s1_kx_r;
  logic [IN_COORD_W-1:0] s1_ky_r;
  dir_t                  s1_dir_r;
  logic                  s1_add_r;
  logic [DRAW_W-1:0]     s1_draw_r;

  // update stage
  logic              s2_valid_r;
  plan_t             s2_plan_r;
  logic              s2_add_r;
  logic [DRAW_W-1:0] s2_draw_r;

  // forwarding of a bond written while it is read
  logic                  fwd_hit_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  // worm and totals
  site_t             head_r;
  site_t             tail_r;
  logic [SUM_W-1:0]  bond_sum_r;
  logic [RUN_W-1:0]  run_r;
  logic [KICK_W-1:0] kick_r;

  // result register
  logic                  out_valid_r;
  site_t                 out_head_r;
  site_t                 out_tail_r;
  logic [BOND_W-1:0]     out_bidx_r;
  logic [COUNT_BITS-1:0] out_count_r;
  logic                  out_acc_r;
  logic                  out_closed_r;

  // combinational
  logic                  s2_fire;
  logic                  issue;
  logic                  in_xfer;
  plan_t                 plan_reg;
  plan_t                 plan_acc;
  plan_t                 plan_rej;
  plan_t                 plan_iss;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] n_cur;
  logic [COUNT_BITS:0]   n_inc;
  logic [MA_W-1:0]       mul_a;
  logic [MB_W-1:0]       mul_b;
  logic [PROD_W-1:0]     prod;
  logic                  acc;
  logic [COUNT_BITS-1:0] n_new;
  site_t                 head_new;
  logic                  closed_new;
  logic [SUM_W-1:0]      bond_sum_nxt;
  logic [RUN_W:0]        run_diff;
  logic [RUN_W-1:0]      run_nxt;
  logic [KICK_W-1:0]     kick_nxt;
  logic                  ram_we;
  logic [BOND_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;

  // handshake and stage advance
  assign s2_fire  = s2_valid_r && (!out_valid_r || out_ready);
  assign issue    = s1_valid_r && (!s2_valid_r || s2_fire);
  assign in_ready = clear_done_r && (!s1_valid_r || issue);
  assign in_xfer  = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coupling_r    <= CFG_RESET;
      temperature_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COUPLING:    coupling_r    <= cfg_wdata;
        REG_TEMPERATURE: temperature_r <= cfg_wdata;
        default:         coupling_r    <= coupling_r;
      endcase
    end
  end

  // bond ram clearing after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_idx_r  <= '0;
      clear_done_r <= 1'b0;
    end else if (!clear_done_r) begin
      clear_idx_r <= clear_idx_r + BOND_W'(1);
      if (clear_idx_r == BOND_W'(NBONDS - 1)) begin
        clear_done_r <= 1'b1;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (issue) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kx_r   <= in_kick_x;
      s1_ky_r   <= in_kick_y;
      s1_dir_r  <= dir_t'(in_direction);
      s1_add_r  <= in_add_bond;
      s1_draw_r <= in_accept_draw;
    end
  end

  // next bond address for every possible worm state
  assign plan_reg = plan_move(head_r, tail_r, s1_kx_r, s1_ky_r, s1_dir_r);
  assign plan_acc = plan_move(s2_plan_r.nbr, s2_plan_r.tail, s1_kx_r, s1_ky_r, s1_dir_r);
  assign plan_rej = plan_move(s2_plan_r.head, s2_plan_r.tail, s1_kx_r, s1_ky_r, s1_dir_r);
  assign plan_iss = s2_fire ? (acc ? plan_acc : plan_rej) : plan_reg;

  // update stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (issue) begin
      s2_valid_r <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_plan_r <= plan_iss;
      s2_add_r  <= s1_add_r;
      s2_draw_r <= s1_draw_r;
    end
  end

  // forwarding when the read hits the bond written at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (issue) begin
      fwd_hit_r <= s2_fire && acc && (plan_iss.bidx == s2_plan_r.bidx);
    end else if (s2_fire) begin
      fwd_hit_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      fwd_data_r <= n_new;
    end
  end

  // acceptance test on a shared multiplier
  assign n_cur = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign n_inc = {1'b0, n_cur} + (COUNT_BITS+1)'(1);
  assign mul_a = s2_add_r ? MA_W'(s2_draw_r) : MA_W'(n_cur);
  assign mul_b = s2_add_r ? MB_W'(n_inc) : MB_W'(temperature_r);
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    if (s2_add_r) begin
      acc = (n_cur != COUNT_MAX) && (prod < PROD_W'(coupling_r));
    end else begin
      acc = PROD_W'(s2_draw_r) < prod;
    end
  end

  // new bond count, head and bond sum
  always_comb begin
    n_new        = n_cur;
    bond_sum_nxt = bond_sum_r;
    if (acc) begin
      if (s2_add_r) begin
        n_new        = COUNT_BITS'(n_inc);
        bond_sum_nxt = bond_sum_r + SUM_W'(1);
      end else begin
        n_new        = n_cur - COUNT_BITS'(1);
        bond_sum_nxt = bond_sum_r - SUM_W'(1);
      end
    end
  end

  assign head_new   = acc ? s2_plan_r.nbr : s2_plan_r.head;
  assign closed_new = acc ? s2_plan_r.closes : s2_plan_r.kicked;

  // kick bookkeeping, uses the bond sum before this move
  assign run_diff = {run_r[RUN_W-1], run_r} - (RUN_W+1)'(bond_sum_r);

  always_comb begin
    run_nxt  = run_r;
    kick_nxt = kick_r;
    if (s2_plan_r.kicked) begin
      run_nxt = (run_diff[RUN_W] && !run_diff[RUN_W-1]) ? RUN_MIN : run_diff[RUN_W-1:0];
      if (kick_r != KICK_MAX) begin
        kick_nxt = kick_r + KICK_W'(1);
      end
    end
  end

  // worm state and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      bond_sum_r <= '0;
      run_r      <= '0;
      kick_r     <= '0;
    end else if (s2_fire) begin
      head_r     <= head_new;
      tail_r     <= s2_plan_r.tail;
      bond_sum_r <= bond_sum_nxt;
      run_r      <= run_nxt;
      kick_r     <= kick_nxt;
    end
  end

  // bond ram
  assign ram_we    = !clear_done_r || (s2_fire && acc);
  assign ram_waddr = clear_done_r ? s2_plan_r.bidx : clear_idx_r;
  assign ram_wdata = clear_done_r ? n_new : '0;

  iwms_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NBONDS)
  ) u_bond_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (plan_iss.bidx),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_head_r   <= head_new;
      out_tail_r   <= s2_plan_r.tail;
      out_bidx_r   <= s2_plan_r.bidx;
      out_count_r  <= n_new;
      out_acc_r    <= acc;
      out_closed_r <= closed_new;
    end
  end

  // totals are read from the state registers, valid while the result waits
  assign out_valid            = out_valid_r;
  assign out_head_col         = OUT_COORD_W'(out_head_r.col);
  assign out_head_row         = OUT_COORD_W'(out_head_r.row);
  assign out_tail_col         = OUT_COORD_W'(out_tail_r.col);
  assign out_tail_row         = OUT_COORD_W'(out_tail_r.row);
  assign out_bond_index       = OUT_BOND_W'(out_bidx_r);
  assign out_bond_count       = OUT_COUNT_W'(out_count_r);
  assign out_accepted         = out_acc_r;
  assign out_worm_closed      = out_closed_r;
  assign out_kick_total       = kick_r;
  assign out_bond_sum         = bond_sum_r;
  assign out_bond_sum_running = $signed(run_r);

  // checks
  `ASSERT_NEVER(a_move_during_clear, s2_valid_r && !clear_done_r, "move in flight while clearing")
  `ASSERT_CLKD(a_out_from_fire, $rose(out_valid_r) |-> $past(s2_fire), "result without a move")
  `ASSERT_CLKD(a_fwd_needs_move, fwd_hit_r |-> s2_valid_r, "forward hit with no move in flight")
  `ASSERT_CLKD(a_sum_on_accept, (bond_sum_r != $past(bond_sum_r)) |-> $past(s2_fire && acc), "bond sum changed without an accepted move")
  `ASSERT_CLKD(a_head_holds, !$past(s2_fire) |-> $stable(head_r), "head moved without a move")

endmodule
